// ===== src/url_percent_decode_path_check_core_assert.svh =====
// Assertion macros for the per-byte parser of the URL decoder and path checker RTL.
`ifndef URL_PERCENT_DECODE_PATH_CHECK_CORE_ASSERT_SVH
`define URL_PERCENT_DECODE_PATH_CHECK_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled during reset.
`define UPDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("updc assertion failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define UPDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("updc assertion failed");
`else
`define UPDC_ASSERT_IMP(lbl, ante, cons)
`define UPDC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/updc_pkg.sv =====
// Types, character codes and helper functions for the URL decoder and path checker.
package updc_pkg;

  // One raw URL byte with its end marker.
  typedef struct packed {
    logic [7:0] url_byte;
    logic       final_byte;
  } in_item_t;

  // One result: a decoded byte, a verdict, or both.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] decoded_byte;
    logic       in_path;
    logic       url_done;
    logic       accepted;
  } out_item_t;

  // Parser position: six prefix characters, then host, path and query.
  typedef enum logic [3:0] {
    PH_PFX0  = 4'd0,
    PH_PFX1  = 4'd1,
    PH_PFX2  = 4'd2,
    PH_PFX3  = 4'd3,
    PH_PFX4  = 4'd4,
    PH_PFX5  = 4'd5,
    PH_HOST  = 4'd6,
    PH_PATH  = 4'd7,
    PH_QUERY = 4'd8
  } phase_t;

  // Progress through a percent escape.
  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_t;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Expected character of the "mod://" prefix at each prefix position.
  function automatic logic [7:0] scheme_char(input phase_t ph);
    logic [7:0] c;
    case (ph)
      PH_PFX0: c = 8'h6D;
      PH_PFX1: c = 8'h6F;
      PH_PFX2: c = 8'h64;
      PH_PFX3: c = CH_COLON;
      PH_PFX4: c = CH_SLASH;
      PH_PFX5: c = CH_SLASH;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // Hex digit value; bit 4 is set when the byte is a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b1, 4'(c - 8'h37)};
    end
    return v;
  endfunction

endpackage

// ===== src/url_percent_decode_path_check_core.sv =====
// Top level of the mod:// URL percent decoder and path checker.
//
//   Channel | Ports                          | Transaction
//   input   | in_valid, in_ready, in_data    | one raw URL byte and its last-byte marker
//   output  | out_valid, out_ready, out_data | one decoded byte and/or the URL verdict
//
// One byte per cycle unless out_ready is low; bytes go input register, then result register.
// The parser state (phase, escape progress, segment flags) feeds back through a single register.
// A byte that produces no result passes through without occupying the result register.
// Synchronous active-low reset clears the valid flags and the parser state; no clearing pass.
// While out_ready is low the result holds, and one more byte may wait in the input register.
module url_percent_decode_path_check_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  updc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output updc_pkg::out_item_t out_data
);
  import updc_pkg::*;

  logic      advance;
  logic      hold_valid;
  in_item_t  hold_item;
  logic      has_result;
  out_item_t result;

  // Input register.
  updc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // Parser and checker.
  updc_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .item       (hold_item),
    .has_result (has_result),
    .result     (result)
  );

  // Result register.
  updc_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .src_valid      (hold_valid),
    .src_has_result (has_result),
    .src_result     (result),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

// ===== src/updc_in_stage.sv =====
// Input register stage: holds one accepted URL byte until the parser takes it.
module updc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  updc_pkg::in_item_t in_data,
  input  logic               advance,
  output logic               hold_valid,
  output updc_pkg::in_item_t hold_item
);
  import updc_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // The stage takes a new byte when empty or when its byte moves on this cycle.
  assign in_ready   = !valid_r || advance;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

// ===== src/updc_step.sv =====
// Per-byte parser: prefix match, percent decoding, host and path checks and verdict.
module updc_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  updc_pkg::in_item_t  item,
  output logic                has_result,
  output updc_pkg::out_item_t result
);
  import updc_pkg::*;

  `include "url_percent_decode_path_check_core_assert.svh"

  phase_t     phase_r, phase_nxt;
  esc_t       esc_r, esc_nxt;
  logic [3:0] high_r, high_nxt;
  logic       part_r, part_nxt;
  logic       tail_r, tail_nxt;
  logic       rej_r, rej_nxt;

  logic       take;
  logic [7:0] raw_c;
  logic [7:0] dec_c;
  logic [4:0] hexv;
  logic       emit;

  assign hexv = hex_digit(item.url_byte);

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    high_nxt  = high_r;
    part_nxt  = part_r;
    tail_nxt  = tail_r;
    rej_nxt   = rej_r;
    take      = 1'b0;
    raw_c     = item.url_byte;
    dec_c     = CH_NUL;
    emit      = 1'b0;

    if (!rej_r) begin
      if (phase_r < PH_HOST) begin
        // Prefix match.
        if (item.url_byte != scheme_char(phase_r)) begin
          rej_nxt = 1'b1;
        end else begin
          phase_nxt = phase_t'(phase_r + 4'd1);
        end
      end else if (phase_r == PH_HOST || phase_r == PH_PATH) begin
        if (esc_r != ESC_NONE) begin
          // Hex digits of an escape.
          if (!hexv[4]) begin
            rej_nxt = 1'b1;
            esc_nxt = ESC_NONE;
          end else if (esc_r == ESC_HIGH) begin
            high_nxt = hexv[3:0];
            esc_nxt  = ESC_LOW;
          end else begin
            esc_nxt = ESC_NONE;
            take    = 1'b1;
            raw_c   = {high_r, hexv[3:0]};
          end
        end else if (item.url_byte == CH_PERCENT) begin
          esc_nxt = ESC_HIGH;
        end else if (item.url_byte == CH_QUESTION) begin
          // Query start closes the last path segment; a query straight after the host rejects the URL.
          if (phase_r == PH_HOST) begin
            rej_nxt = 1'b1;
          end else begin
            if (!part_r || tail_r) begin
              rej_nxt = 1'b1;
            end
            part_nxt = 1'b0;
            tail_nxt = 1'b0;
          end
          phase_nxt = PH_QUERY;
        end else if (item.url_byte == CH_SLASH && phase_r == PH_HOST) begin
          // First raw slash closes the host.
          if (!part_r || tail_r) begin
            rej_nxt = 1'b1;
          end
          part_nxt  = 1'b0;
          tail_nxt  = 1'b0;
          phase_nxt = PH_PATH;
        end else begin
          take = 1'b1;
        end
      end
    end

    // A decoded byte of the host or path.
    if (take) begin
      dec_c = (raw_c == CH_BACKSLASH) ? CH_SLASH : raw_c;
      if (dec_c == CH_NUL || dec_c == CH_PERCENT || dec_c == CH_COLON) begin
        rej_nxt = 1'b1;
      end else if (dec_c == CH_SLASH) begin
        if (phase_r == PH_HOST) begin
          rej_nxt = 1'b1;
        end else begin
          if (!part_r || tail_r) begin
            rej_nxt = 1'b1;
          end
          part_nxt = 1'b0;
          tail_nxt = 1'b0;
        end
      end else begin
        part_nxt = 1'b1;
        tail_nxt = (dec_c == CH_DOT || dec_c == CH_SPACE);
      end
      emit = !rej_nxt;
    end

    // Verdict on the last byte.
    if (item.final_byte && !rej_nxt) begin
      if (phase_nxt == PH_PATH) begin
        if (esc_nxt != ESC_NONE || !part_nxt || tail_nxt) begin
          rej_nxt = 1'b1;
        end
      end else if (phase_nxt != PH_QUERY) begin
        rej_nxt = 1'b1;
      end
    end

    result.byte_valid   = emit;
    result.decoded_byte = emit ? dec_c : CH_NUL;
    result.in_path      = emit && (phase_r == PH_PATH);
    result.url_done     = item.final_byte;
    result.accepted     = item.final_byte && !rej_nxt;
    has_result          = emit || item.final_byte;

    // Every URL starts from the reset state.
    if (item.final_byte) begin
      phase_nxt = PH_PFX0;
      esc_nxt   = ESC_NONE;
      high_nxt  = 4'd0;
      part_nxt  = 1'b0;
      tail_nxt  = 1'b0;
      rej_nxt   = 1'b0;
    end
  end

  // Parser state, updated as each byte moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PFX0;
      esc_r   <= ESC_NONE;
      high_r  <= 4'd0;
      part_r  <= 1'b0;
      tail_r  <= 1'b0;
      rej_r   <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      high_r  <= high_nxt;
      part_r  <= part_nxt;
      tail_r  <= tail_nxt;
      rej_r   <= rej_nxt;
    end
  end

  // An escape is only ever pending inside the host or the path.
  `UPDC_ASSERT_IMP(a_esc_phase, esc_r != ESC_NONE, phase_r == PH_HOST || phase_r == PH_PATH)
  // Once rejected, no further decoded byte is emitted.
  `UPDC_ASSERT_IMP(a_rej_silent, rej_r, !result.byte_valid)
  // A last byte returns the parser to its reset state.
  `UPDC_ASSERT_NXT(a_final_reset, advance && item.final_byte,
                   phase_r == PH_PFX0 && esc_r == ESC_NONE && !rej_r && !part_r)
  // A verdict is only given on the last byte.
  `UPDC_ASSERT_IMP(a_verdict_final, result.accepted, result.url_done && has_result)

endmodule

// ===== src/updc_out_stage.sv =====
// Result register stage: holds one result until the consumer takes it.
module updc_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                src_valid,
  input  logic                src_has_result,
  input  updc_pkg::out_item_t src_result,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_ready,
  output updc_pkg::out_item_t out_data
);
  import updc_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  logic      room;

  // The register is free when empty or being read this cycle.
  assign room      = !valid_r || out_ready;
  assign advance   = src_valid && room;
  assign out_valid = valid_r;
  assign out_data  = item_r;

  // Valid flag; a byte that causes no result leaves the register empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= src_valid && src_has_result;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      item_r <= src_result;
    end
  end

endmodule
